### sv/rcm_pkg.sv
// Shared types, codes and constants for the raised-cosine membership block.
// No dependencies; every other file imports this package.
package rcm_pkg;

	// Number formats
	localparam int VALUE_WIDTH   = 32;
	localparam int OUT_FRAC_BITS = 16;
	localparam int PHASE_BITS    = 16;
	localparam int OUT_WIDTH     = OUT_FRAC_BITS + 1;

	localparam logic [OUT_WIDTH-1:0] OUT_ONE = OUT_WIDTH'(1) << OUT_FRAC_BITS;

	// Kind codes
	localparam logic [1:0] KIND_VALUE   = 2'd0;
	localparam logic [1:0] KIND_MISSING = 2'd1;
	localparam logic [1:0] KIND_NAN     = 2'd2;
	localparam logic [1:0] KIND_UNUSED  = 2'd3;

	// Register indexes
	localparam int CFG_INDEX_WIDTH = 3;
	localparam logic [2:0] REG_LEFT_EDGE       = 3'd0;
	localparam logic [2:0] REG_LEFT_TOP        = 3'd1;
	localparam logic [2:0] REG_RIGHT_TOP       = 3'd2;
	localparam logic [2:0] REG_RIGHT_EDGE      = 3'd3;
	localparam logic [2:0] REG_LEFT_UNBOUNDED  = 3'd4;
	localparam logic [2:0] REG_RIGHT_UNBOUNDED = 3'd5;

	// Cosine series constants: pi in Q30 and the Horner divisors
	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam int HORNER_STEPS = 6;
	localparam logic [7:0] HORNER_DIV [HORNER_STEPS] =
		'{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
	// floor(2^32 / k), so that m*R >> 32 is floor(m/k) or one less
	localparam logic [31:0] HORNER_RECIP [HORNER_STEPS] = '{
		32'((64'd1 << 32) / 64'd132), 32'((64'd1 << 32) / 64'd90),
		32'((64'd1 << 32) / 64'd56),  32'((64'd1 << 32) / 64'd30),
		32'((64'd1 << 32) / 64'd12),  32'((64'd1 << 32) / 64'd2)};

	// Pipeline shape of the back end
	localparam int ST_FOLD = PHASE_BITS + 1;
	localparam int ST_ANG  = ST_FOLD + 1;
	localparam int ST_SQR  = ST_ANG + 1;
	localparam int ST_OUT  = ST_SQR + 4 * HORNER_STEPS + 1;
	localparam int NSTG    = ST_OUT + 1;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] sample_value;
		logic [1:0]                    missing_kind;
	} sample_t;

	typedef struct packed {
		logic [OUT_WIDTH-1:0] membership;
		logic [1:0]           result_kind;
	} result_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] left_edge;
		logic signed [VALUE_WIDTH-1:0] left_top;
		logic signed [VALUE_WIDTH-1:0] right_top;
		logic signed [VALUE_WIDTH-1:0] right_edge;
		logic                          left_unbounded;
		logic                          right_unbounded;
	} cfg_t;

	// Classification carried alongside a request
	typedef struct packed {
		logic [1:0]           kind;
		logic                 on_edge;
		logic [OUT_WIDTH-1:0] direct;
	} job_t;

	typedef struct packed {
		job_t                   job;
		logic [VALUE_WIDTH-1:0] distance;
		logic [VALUE_WIDTH-1:0] width;
	} work_t;

endpackage

### sv/raised_cosine_membership.sv
// Top level of the raised-cosine membership block: registers, front end, queue, back end.
// Depends on rcm_pkg, rcm_front, rcm_queue, rcm_back.
//
//  channel   signals                          direction  payload
//  sample    sample_valid/sample_ready        in         sample_value, missing_kind
//  result    result_valid/result_ready        out        membership, result_kind
//  config    cfg_we, cfg_index, cfg_data      in         one register per write
//
// One sample per cycle sustained while results are taken; a sample passes the
// 16-stage phase divider and the 24-stage cosine series on its way to the result.
// arst_n clears the pipeline valids, queue pointers and registers to their reset values.
// A stalled result freezes the back end; the 4-entry queue keeps taking
// requests until it is full.
module raised_cosine_membership (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_valid,
	output logic                                  sample_ready,
	input  rcm_pkg::sample_t                      sample,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output rcm_pkg::result_t                      result,
	input  logic                                  cfg_we,
	input  logic [rcm_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [rcm_pkg::VALUE_WIDTH-1:0]       cfg_data
);
	import rcm_pkg::*;

	cfg_t  cfg_q;
	work_t front_work, head;
	logic  q_full, q_empty, take;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_edge       <= 32'sd0;
			cfg_q.left_top        <= 32'sd65536;
			cfg_q.right_top       <= 32'sd131072;
			cfg_q.right_edge      <= 32'sd196608;
			cfg_q.left_unbounded  <= 1'b0;
			cfg_q.right_unbounded <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEFT_EDGE:       cfg_q.left_edge       <= cfg_data;
				REG_LEFT_TOP:        cfg_q.left_top        <= cfg_data;
				REG_RIGHT_TOP:       cfg_q.right_top       <= cfg_data;
				REG_RIGHT_EDGE:      cfg_q.right_edge      <= cfg_data;
				REG_LEFT_UNBOUNDED:  cfg_q.left_unbounded  <= cfg_data[0];
				REG_RIGHT_UNBOUNDED: cfg_q.right_unbounded <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign sample_ready = !q_full;

	rcm_front u_front (
		.sample (sample),
		.cfg    (cfg_q),
		.work   (front_work)
	);

	rcm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (sample_valid && !q_full),
		.push_item (front_work),
		.full      (q_full),
		.pop       (take),
		.empty     (q_empty),
		.head      (head)
	);

	rcm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.avail        (!q_empty),
		.take         (take),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

### sv/rcm_front.sv
// Front end: classifies a sample against the breakpoints and forms edge distance/width.
// Depends on rcm_pkg.
module rcm_front (
	input  rcm_pkg::sample_t sample,
	input  rcm_pkg::cfg_t    cfg,
	output rcm_pkg::work_t   work
);
	import rcm_pkg::*;

	logic below, above, rising, flat;
	logic [VALUE_WIDTH:0] d_rise, w_rise, d_fall, w_fall;

	// Signed order of sample and breakpoints
	assign below  = !cfg.left_unbounded && (sample.sample_value < cfg.left_edge);
	assign above  = !cfg.right_unbounded && (sample.sample_value > cfg.right_edge);
	assign rising = sample.sample_value < cfg.left_top;
	assign flat   = sample.sample_value <= cfg.right_top;

	// Distances are positive and fit VALUE_WIDTH bits wherever they are used
	assign d_rise = {cfg.left_top[VALUE_WIDTH-1], cfg.left_top}
		- {sample.sample_value[VALUE_WIDTH-1], sample.sample_value};
	assign w_rise = {cfg.left_top[VALUE_WIDTH-1], cfg.left_top}
		- {cfg.left_edge[VALUE_WIDTH-1], cfg.left_edge};
	assign d_fall = {sample.sample_value[VALUE_WIDTH-1], sample.sample_value}
		- {cfg.right_top[VALUE_WIDTH-1], cfg.right_top};
	assign w_fall = {cfg.right_edge[VALUE_WIDTH-1], cfg.right_edge}
		- {cfg.right_top[VALUE_WIDTH-1], cfg.right_top};

	// Region decision
	always_comb begin
		work.job.kind    = KIND_VALUE;
		work.job.on_edge = 1'b0;
		work.job.direct  = '0;
		work.distance    = d_rise[VALUE_WIDTH-1:0];
		work.width       = w_rise[VALUE_WIDTH-1:0];
		if (sample.missing_kind != KIND_VALUE) begin
			work.job.kind = (sample.missing_kind == KIND_MISSING) ? KIND_MISSING : KIND_NAN;
		end else if (below || above) begin
			work.job.direct = '0;
		end else if (rising) begin
			if (cfg.left_unbounded) begin
				work.job.direct = OUT_ONE;
			end else begin
				work.job.on_edge = 1'b1;
			end
		end else if (flat) begin
			work.job.direct = OUT_ONE;
		end else if (cfg.right_unbounded) begin
			work.job.direct = OUT_ONE;
		end else begin
			work.job.on_edge = 1'b1;
			work.distance    = d_fall[VALUE_WIDTH-1:0];
			work.width       = w_fall[VALUE_WIDTH-1:0];
		end
	end

endmodule

### sv/rcm_queue.sv
// Short request queue between the front end and the back end pipeline.
// Depends on rcm_pkg.
module rcm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rcm_pkg::work_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output rcm_pkg::work_t head
);
	import rcm_pkg::*;

	work_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_WIDTH-1:0] wr_q, rd_q;
	logic [QPTR_WIDTH:0]   count_q;

	assign full  = count_q == (QPTR_WIDTH+1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

endmodule

### sv/rcm_back.sv
// Back end: pipelined restoring divider for the phase, then the cosine series.
// Depends on rcm_pkg.
module rcm_back (
	input  logic             clk,
	input  logic             arst_n,
	input  rcm_pkg::work_t   head,
	input  logic             avail,
	output logic             take,
	output logic             result_valid,
	input  logic             result_ready,
	output rcm_pkg::result_t result
);
	import rcm_pkg::*;

	logic                   en;
	logic [NSTG-1:0]        vld_s;
	job_t                   job_s [NSTG];
	logic                   inv_s [NSTG];

	logic [VALUE_WIDTH-1:0] dr_s [PHASE_BITS+1];
	logic [VALUE_WIDTH-1:0] dw_s [PHASE_BITS+1];
	logic [PHASE_BITS-1:0]  dq_s [PHASE_BITS+1];
	logic                   dfull_s [PHASE_BITS+1];

	logic [PHASE_BITS:0]    t_full;
	logic                   fold_inv;
	logic [PHASE_BITS:0]    fold_t;
	logic [PHASE_BITS-1:0]  tl_s17;
	logic [47:0]            ang_prod;
	logic [30:0]            ang_s18;
	logic [61:0]            sqr_prod;
	logic [31:0]            sqr_s19;

	logic [31:0]            hs_d [HORNER_STEPS];
	logic signed [32:0]     hp_d [HORNER_STEPS];

	logic signed [32:0]     p_fin;
	logic [31:0]            p_clamp;
	logic [31:0]            p_round;
	logic [OUT_WIDTH-1:0]   half_val;
	logic [OUT_WIDTH-1:0]   edge_val;
	result_t                res_s44;

	// Whole pipeline moves when the output register is free or being taken
	assign en           = !vld_s[NSTG-1] || result_ready;
	assign take         = en && avail;
	assign result_valid = vld_s[NSTG-1];
	assign result       = res_s44;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NSTG-2:0], take};
		end
	end

	// Control and divider load stage
	always_ff @(posedge clk) begin
		if (en) begin
			job_s[0]   <= head.job;
			inv_s[0]   <= 1'b0;
			dr_s[0]    <= head.distance;
			dw_s[0]    <= head.width;
			dq_s[0]    <= '0;
			dfull_s[0] <= head.distance >= head.width;
			for (int i = 1; i < NSTG; i++) begin
				job_s[i] <= job_s[i-1];
				inv_s[i] <= (i == ST_FOLD) ? fold_inv : inv_s[i-1];
			end
		end
	end

	// Restoring division, one quotient bit per stage
	for (genvar i = 1; i <= PHASE_BITS; i++) begin : g_div
		logic [VALUE_WIDTH:0] two_r;
		logic                 ge;
		assign two_r = {dr_s[i-1], 1'b0};
		assign ge    = two_r >= {1'b0, dw_s[i-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				dr_s[i]    <= ge ? VALUE_WIDTH'(two_r - {1'b0, dw_s[i-1]})
				                 : two_r[VALUE_WIDTH-1:0];
				dq_s[i]    <= {dq_s[i-1][PHASE_BITS-2:0], ge};
				dw_s[i]    <= dw_s[i-1];
				dfull_s[i] <= dfull_s[i-1];
			end
		end
	end

	// Fold the phase onto [0, 1/2]; upper half is mirrored at the end
	assign t_full   = dfull_s[PHASE_BITS] ? (PHASE_BITS+1)'(1) << PHASE_BITS
	                                      : {1'b0, dq_s[PHASE_BITS]};
	assign fold_inv = t_full > ((PHASE_BITS+1)'(1) << (PHASE_BITS-1));
	assign fold_t   = fold_inv ? ((PHASE_BITS+1)'(1) << PHASE_BITS) - t_full : t_full;

	// Angle in Q30, then its square
	assign ang_prod = 48'(tl_s17) * 48'(PI_Q30);
	assign sqr_prod = 62'(ang_s18) * 62'(ang_s18);

	always_ff @(posedge clk) begin
		if (en) begin
			tl_s17  <= fold_t[PHASE_BITS-1:0];
			ang_s18 <= ang_prod[46:16];
			sqr_s19 <= sqr_prod[61:30];
		end
	end

	// Horner steps: p = 1 - trunc(s*p / (k * 2^30)), four stages each
	for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
		logic [31:0]        s_in;
		logic signed [32:0] p_in;
		logic signed [65:0] prod_a;
		logic [31:0]        s_a, s_b, s_c;
		logic [65:0]        mag;
		logic [31:0]        m_b, m_c, q_c;
		logic               neg_b, neg_c;
		logic [63:0]        est;
		logic [39:0]        rem;
		logic [32:0]        q_fix;
		logic signed [34:0] p_new;

		if (j == 0) begin : g_first
			assign s_in = sqr_s19;
			assign p_in = 33'sd1 <<< 30;
		end else begin : g_next
			assign s_in = hs_d[j-1];
			assign p_in = hp_d[j-1];
		end

		assign mag   = prod_a[65] ? 66'(-prod_a) : 66'(prod_a);
		assign est   = 64'(m_b) * 64'(HORNER_RECIP[j]);
		assign rem   = 40'(m_c) - 40'(q_c) * 40'(HORNER_DIV[j]);
		assign q_fix = 33'(q_c) + 33'(rem >= 40'(HORNER_DIV[j]));
		assign p_new = neg_c ? (35'sd1 <<< 30) + $signed({2'b00, q_fix})
		                     : (35'sd1 <<< 30) - $signed({2'b00, q_fix});

		always_ff @(posedge clk) begin
			if (en) begin
				prod_a  <= $signed({1'b0, s_in}) * p_in;
				s_a     <= s_in;
				m_b     <= mag[61:30];
				neg_b   <= prod_a[65];
				s_b     <= s_a;
				q_c     <= est[63:32];
				m_c     <= m_b;
				neg_c   <= neg_b;
				s_c     <= s_b;
				hp_d[j] <= p_new[32:0];
				hs_d[j] <= s_c;
			end
		end
	end

	// Clamp, round to the output format, mirror the upper half
	assign p_fin    = hp_d[HORNER_STEPS-1];
	assign p_clamp  = p_fin[32] ? 32'd0
	                : (p_fin > (33'sd1 <<< 30)) ? 32'd1 << 30 : p_fin[31:0];
	assign p_round  = (32'd1 << 30) + p_clamp + (32'd1 << (30 - OUT_FRAC_BITS));
	assign half_val = p_round[31:31-OUT_FRAC_BITS];
	assign edge_val = inv_s[NSTG-2] ? OUT_ONE - half_val : half_val;

	always_ff @(posedge clk) begin
		if (en) begin
			res_s44.result_kind <= job_s[NSTG-2].kind;
			res_s44.membership  <= job_s[NSTG-2].on_edge ? edge_val : job_s[NSTG-2].direct;
		end
	end

endmodule

### sv/rcm_checker.sv
// Port-level checks for the raised-cosine membership block, bound to the top level.
// Depends on rcm_pkg and raised_cosine_membership.
module rcm_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_ready,
	input rcm_pkg::result_t result
);
	import rcm_pkg::*;

	// A stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its value
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result))
		else $error("result changed while stalled");

	// The unused kind code never leaves the block
	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.result_kind != KIND_UNUSED)
		else $error("unused result kind");

	// Missing and not-a-number requests carry zero membership
	a_missing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.result_kind != KIND_VALUE |-> result.membership == '0)
		else $error("non-zero membership on missing request");

	// Membership never exceeds one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.membership <= OUT_ONE)
		else $error("membership above one");

endmodule

bind raised_cosine_membership rcm_checker u_rcm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

### bench/raised_cosine_membership_test.sv
// Self-checking bench for the raised-cosine membership block.
// Depends on rcm_pkg and raised_cosine_membership; directed table then random requests.
module raised_cosine_membership_test;
	import rcm_pkg::*;

	localparam int TIMEOUT_CYCLES = 20000;
	localparam int DRAIN_CYCLES   = 60;
	localparam logic [16:0] FULL_PHASE = 17'h10000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	sample_t sample = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [VALUE_WIDTH-1:0] cfg_data = '0;

	raised_cosine_membership u_dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow of the breakpoint registers
	cfg_t shadow_cfg;
	result_t pending_results[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off_cycles = 0;

	// Cosine half: t in 0..0.5 of full phase, membership rounded to Q1.16
	function automatic logic [16:0] cos_half(input logic [16:0] t);
		logic [63:0] ang, sq;
		longint signed p;
		longint signed divs[6];
		divs = '{132, 90, 56, 30, 12, 2};
		ang = (64'(t) * 64'(PI_Q30)) >> PHASE_BITS;
		sq = (ang * ang) >> 30;
		p = 64'sd1 << 30;
		for (int i = 0; i < 6; i++)
			p = (64'sd1 << 30) - (longint'(sq) * p) / (divs[i] * (64'sd1 << 30));
		if (p < 0) p = 0;
		if (p > (64'sd1 << 30)) p = 64'sd1 << 30;
		return 17'((64'((64'sd1 << 30) + p) + 64'd16384) >> 15);
	endfunction

	// Membership on an edge of width w at distance d
	function automatic logic [16:0] edge_membership(input logic [63:0] d, input logic [63:0] w);
		logic [63:0] r;
		logic [16:0] t;
		if (w == 0) return 17'd0;
		if (d >= w) t = FULL_PHASE;
		else begin
			r = d;
			t = '0;
			for (int i = 0; i < PHASE_BITS; i++) begin
				t = t << 1;
				if (r >= w - r) begin
					r = r - (w - r);
					t[0] = 1'b1;
				end else begin
					r = r << 1;
				end
			end
		end
		if (t <= (FULL_PHASE >> 1)) return cos_half(t);
		return OUT_ONE - cos_half(FULL_PHASE - t);
	endfunction

	function automatic result_t membership_of(input sample_t s);
		result_t r;
		longint signed x, lo, c1, c2, hi;
		r = '0;
		if (s.missing_kind != KIND_VALUE) begin
			r.result_kind = (s.missing_kind == KIND_MISSING) ? KIND_MISSING : KIND_NAN;
			return r;
		end
		x = s.sample_value;
		lo = shadow_cfg.left_edge;
		c1 = shadow_cfg.left_top;
		c2 = shadow_cfg.right_top;
		hi = shadow_cfg.right_edge;
		r.result_kind = KIND_VALUE;
		if ((!shadow_cfg.left_unbounded && x < lo) || (!shadow_cfg.right_unbounded && x > hi))
			r.membership = '0;
		else if (x < c1)
			r.membership = shadow_cfg.left_unbounded ? OUT_ONE : edge_membership(c1 - x, c1 - lo);
		else if (x <= c2)
			r.membership = OUT_ONE;
		else
			r.membership = shadow_cfg.right_unbounded ? OUT_ONE : edge_membership(x - c2, hi - c2);
		return r;
	endfunction

	// One register write; the caller drops the write enable after the last one
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_LEFT_EDGE:       shadow_cfg.left_edge = val;
			REG_LEFT_TOP:        shadow_cfg.left_top = val;
			REG_RIGHT_TOP:       shadow_cfg.right_top = val;
			REG_RIGHT_EDGE:      shadow_cfg.right_edge = val;
			REG_LEFT_UNBOUNDED:  shadow_cfg.left_unbounded = val[0];
			REG_RIGHT_UNBOUNDED: shadow_cfg.right_unbounded = val[0];
			default: ;
		endcase
	endtask

	task automatic set_shape(input logic [31:0] le, lt, rt, re, input logic lu, ru);
		write_reg(REG_LEFT_EDGE, le);
		write_reg(REG_LEFT_TOP, lt);
		write_reg(REG_RIGHT_TOP, rt);
		write_reg(REG_RIGHT_EDGE, re);
		write_reg(REG_LEFT_UNBOUNDED, {31'd0, lu});
		write_reg(REG_RIGHT_UNBOUNDED, {31'd0, ru});
		cfg_we <= 1'b0;
	endtask

	// Offer one request, wait for acceptance, queue its expectation
	task automatic send_request(input sample_t s, input bit typed, input result_t typed_res);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		pending_results.push_back(typed ? typed_res : membership_of(s));
	endtask

	task automatic wait_drained();
		sample_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] near(input logic [31:0] base);
		return base + 32'($signed($urandom_range(262144)) - 131072);
	endfunction

	// Random sample: mostly around breakpoints, some wide values and markers
	function automatic sample_t random_sample();
		sample_t s;
		int pick;
		pick = $urandom_range(9);
		s.missing_kind = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : KIND_VALUE;
		case (pick)
			0: s.sample_value = $urandom;
			1: s.sample_value = near(shadow_cfg.left_edge);
			2: s.sample_value = near(shadow_cfg.right_edge);
			3, 4: s.sample_value = shadow_cfg.left_edge +
				32'(($urandom % (64'(shadow_cfg.left_top - shadow_cfg.left_edge) + 1)));
			5, 6: s.sample_value = shadow_cfg.right_top +
				32'(($urandom % (64'(shadow_cfg.right_edge - shadow_cfg.right_top) + 1)));
			default: s.sample_value = near(shadow_cfg.left_top);
		endcase
		return s;
	endfunction

	// Result checker and receiver stalls
	always @(posedge clk) begin
		result_t want;
		if (result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", result);
			end else begin
				want = pending_results.pop_front();
				if (result.membership !== want.membership ||
						result.result_kind !== want.result_kind) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected m=%0d k=%0d, got m=%0d k=%0d",
							want.membership, want.result_kind,
							result.membership, result.result_kind);
				end
			end
		end
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= TIMEOUT_CYCLES) begin
			$display("raised_cosine_membership verification failed");
			$finish;
		end
	end

	typedef struct {
		sample_t s;
		bit      typed;
		result_t res;
	} directed_row_t;

	initial begin
		directed_row_t rows[$];
		sample_t s;
		shadow_cfg = '{left_edge: 32'd0, left_top: 32'd65536, right_top: 32'd131072,
			right_edge: 32'd196608, left_unbounded: 1'b0, right_unbounded: 1'b0};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table under reset shape
		rows = '{
			'{'{32'sd0, KIND_VALUE}, 1, '{17'd0, KIND_VALUE}},
			'{'{32'sd65536, KIND_VALUE}, 1, '{OUT_ONE, KIND_VALUE}},
			'{'{32'sd131072, KIND_VALUE}, 1, '{OUT_ONE, KIND_VALUE}},
			'{'{32'sd196608, KIND_VALUE}, 1, '{17'd0, KIND_VALUE}},
			'{'{-32'sd1, KIND_VALUE}, 1, '{17'd0, KIND_VALUE}},
			'{'{32'sd196609, KIND_VALUE}, 1, '{17'd0, KIND_VALUE}},
			'{'{32'h8000_0000, KIND_VALUE}, 1, '{17'd0, KIND_VALUE}},
			'{'{32'h7fff_ffff, KIND_VALUE}, 1, '{17'd0, KIND_VALUE}},
			'{'{32'sd32768, KIND_VALUE}, 0, '0},
			'{'{32'sd1, KIND_VALUE}, 0, '0},
			'{'{32'sd65535, KIND_VALUE}, 0, '0},
			'{'{32'sd163840, KIND_VALUE}, 0, '0},
			'{'{32'sd131073, KIND_VALUE}, 0, '0},
			'{'{32'sd100, KIND_MISSING}, 1, '{17'd0, KIND_MISSING}},
			'{'{32'hffff_ffff, KIND_NAN}, 1, '{17'd0, KIND_NAN}},
			'{'{32'sd70000, KIND_UNUSED}, 1, '{17'd0, KIND_NAN}}
		};
		foreach (rows[i]) send_request(rows[i].s, rows[i].typed, rows[i].res);
		wait_drained();

		// Unbounded sides at the extremes, then a zero-width rising edge
		set_shape(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 1'b1);
		send_request('{32'h8000_0000, KIND_VALUE}, 1, '{OUT_ONE, KIND_VALUE});
		send_request('{32'h7fff_ffff, KIND_VALUE}, 1, '{OUT_ONE, KIND_VALUE});
		wait_drained();
		set_shape(32'sd1000, 32'sd1000, 32'sd2000, 32'h7fff_ffff, 1'b0, 1'b0);
		send_request('{32'sd1000, KIND_VALUE}, 0, '0);
		send_request('{32'sd999, KIND_VALUE}, 1, '{17'd0, KIND_VALUE});
		send_request('{32'h4000_0000, KIND_VALUE}, 0, '0);
		wait_drained();

		// Random phases over several shapes and idling mixes
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: set_shape(32'hfffe_0000, 32'h0000_8000, 32'h0001_0000, 32'h0003_0000, 0, 0);
				1: set_shape(32'h8000_0000, 32'h0, 32'h1000, 32'h7fff_ffff, 0, 0);
				2: set_shape(32'h100, 32'h200, 32'h300, 32'h400, 1, 0);
				3: set_shape(32'h10000, 32'h8000, 32'h4000, 32'h0, 0, 0);
				4: set_shape($urandom, $urandom, $urandom, $urandom, 0, 1);
				5: set_shape(32'hffff_0000, 32'hffff_0003, 32'hffff_0003, 32'hffff_0010, 0, 0);
				default: set_shape(32'hc000_0000, 32'hf000_0000, 32'h1000_0000, 32'h4000_0000, 0, 0);
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
				default: begin send_idle_pct = 13; recv_stall_pct = 13; end
			endcase
			if (ph == 2) hold_off_cycles = 200;
			for (int n = 0; n < 100; n++) begin
				s = random_sample();
				send_request(s, 0, '0);
			end
			// Sender pauses until all results are in
			wait_drained();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		wait_drained();
		if (mismatches == 0 && pending_results.size() == 0)
			$display("raised_cosine_membership verification clean");
		else
			$display("raised_cosine_membership verification failed");
		$finish;
	end

endmodule
